@@ design/svgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgc_pkg
// Shared types, constants and window arithmetic for the vertical Sobel
// gradient unit.
// ----------------------------------------------------------------------------
package svgc_pkg;

    localparam int PIX_BITS   = 8;
    localparam int REG_BITS   = 10;
    localparam int APB_DATA_BITS = 32;
    localparam int ADDR_BITS  = 3;
    localparam int REG_SEL_BIT = 2;

    localparam logic [REG_BITS-1:0] IMAGE_WIDTH_RESET  = 10'd512;
    localparam logic [REG_BITS-1:0] IMAGE_HEIGHT_RESET = 10'd512;

    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'hFF;

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = 2;
    localparam int FIFO_CNT_BITS  = 3;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // left, centre and right bytes of the bottom and top rows
    typedef struct packed {
        logic [PIX_BITS-1:0] top_l;
        logic [PIX_BITS-1:0] top_c;
        logic [PIX_BITS-1:0] top_r;
        logic [PIX_BITS-1:0] bot_l;
        logic [PIX_BITS-1:0] bot_c;
        logic [PIX_BITS-1:0] bot_r;
    } t_window;

    typedef struct packed {
        logic [PIX_BITS-1:0] gradient;
        logic                frame_end;
    } t_result;

    function automatic t_window window_shift(input t_window w,
                                             input logic [PIX_BITS-1:0] bot,
                                             input logic [PIX_BITS-1:0] top);
        t_window s;
        s.bot_l = w.bot_c;
        s.bot_c = w.bot_r;
        s.bot_r = bot;
        s.top_l = w.top_c;
        s.top_c = w.top_r;
        s.top_r = top;
        return s;
    endfunction

    function automatic logic [PIX_BITS-1:0] window_grad(input t_window w);
        logic [PIX_BITS+1:0]        sum_b;
        logic [PIX_BITS+1:0]        sum_t;
        logic signed [PIX_BITS+2:0] diff;
        logic [PIX_BITS-1:0]        g;
        sum_b = {2'b00, w.bot_l} + {1'b0, w.bot_c, 1'b0} + {2'b00, w.bot_r};
        sum_t = {2'b00, w.top_l} + {1'b0, w.top_c, 1'b0} + {2'b00, w.top_r};
        diff  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
        if (diff[PIX_BITS+2]) begin
            g = '0;
        end else if (diff[PIX_BITS+1:PIX_BITS] != 2'b00) begin
            g = PIX_MAX;
        end else begin
            g = diff[PIX_BITS-1:0];
        end
        return g;
    endfunction

endpackage

@@ design/svgc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgc_if
// Valid/ready stream interfaces for pixel items and gradient items.
// ----------------------------------------------------------------------------
interface svgc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [svgc_pkg::PIX_BITS-1:0] pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface svgc_out_if;
    logic                          valid;
    logic                          ready;
    logic [svgc_pkg::PIX_BITS-1:0] gradient;
    logic                          frame_end;

    modport source (output valid, output gradient, output frame_end, input ready);
    modport sink   (input valid, input gradient, input frame_end, output ready);
endinterface

@@ design/svgc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module svgc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/sobel_vertical_gradient_clamp_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_vertical_gradient_clamp_unit
// Streaming 3x3 vertical Sobel gradient, clamped to 0..255.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one item per clock while input ready is high;
// after width*height pixels the host sends width drain items for the zero row
// below the image. Each item in column C >= 1 yields the gradient of column
// C-1 one row up, and the last column also yields its own, so a row of W items
// gives W results on rows after the first. Results are written into a
// four-entry result queue as the item is taken and leave one per clock while
// the output is ready; input ready drops only when fewer than two queue
// entries are free, so with the output always ready the block takes one item
// per clock with no stall. The two earlier rows live in one MAX_WIDTH x 16
// line memory read one item ahead. No clearing pass is needed after reset. Any
// register write restarts the frame position.
// ----------------------------------------------------------------------------
module sobel_vertical_gradient_clamp_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    svgc_in_if.sink                                i_in,
    svgc_out_if.source                             o_out,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [svgc_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [svgc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [svgc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DWR = $clog2(MAX_WIDTH + 1);
    localparam int DW  = (DWR > svgc_pkg::REG_BITS) ? DWR : svgc_pkg::REG_BITS;
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int HWR = RW;
    localparam int HW  = (HWR > svgc_pkg::REG_BITS) ? HWR : svgc_pkg::REG_BITS;
    localparam int PW  = svgc_pkg::PIX_BITS;
    localparam int MW  = 2 * PW;

    // configuration
    logic [svgc_pkg::REG_BITS-1:0] r_img_width;
    logic [svgc_pkg::REG_BITS-1:0] r_img_height;
    logic                          cfg_wr;
    svgc_pkg::t_reg_idx            reg_idx;

    // position and window
    logic [CW-1:0]         r_col;
    logic [CW-1:0]         n_col;
    logic [RW-1:0]         r_row;
    logic [RW-1:0]         n_row;
    svgc_pkg::t_window     r_win;
    svgc_pkg::t_window     n_win;
    svgc_pkg::t_window     base_win;

    logic [DW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic [DW-1:0]         col_ext;
    logic [HW-1:0]         row_ext;
    logic                  is_last_col;
    logic                  in_image;
    logic                  at_drain_row;
    logic                  row_ge1;
    logic                  row_ge2;

    // line memory and read bypass
    logic [MW-1:0]         ram_rd_data;
    logic [MW-1:0]         pair;
    logic [MW-1:0]         wr_pair;
    logic                  r_byp_vld;
    logic [MW-1:0]         r_byp_data;
    logic [PW-1:0]         v_pix;
    logic [PW-1:0]         t_pix;

    // results and queue
    logic                  accept;
    logic                  res_a_vld;
    logic                  res_b_vld;
    svgc_pkg::t_result     res_a;
    svgc_pkg::t_result     res_b;
    svgc_pkg::t_result     push_first;
    logic                  push0;
    logic                  push1;
    logic                  pop;
    svgc_pkg::t_result     r_fifo [svgc_pkg::FIFO_DEPTH];
    svgc_pkg::t_result     head;
    logic [svgc_pkg::FIFO_PTR_BITS-1:0] r_wp;
    logic [svgc_pkg::FIFO_PTR_BITS-1:0] r_rp;
    logic [svgc_pkg::FIFO_CNT_BITS-1:0] r_cnt;
    logic [svgc_pkg::FIFO_PTR_BITS-1:0] wp_next;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = svgc_pkg::t_reg_idx'(paddr[svgc_pkg::REG_SEL_BIT]);

    always_comb begin
        unique case (reg_idx)
            svgc_pkg::REG_IMAGE_WIDTH: begin
                prdata = svgc_pkg::APB_DATA_BITS'(r_img_width);
            end
            svgc_pkg::REG_IMAGE_HEIGHT: begin
                prdata = svgc_pkg::APB_DATA_BITS'(r_img_height);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= svgc_pkg::IMAGE_WIDTH_RESET;
            r_img_height <= svgc_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                svgc_pkg::REG_IMAGE_WIDTH: begin
                    r_img_width <= pwdata[svgc_pkg::REG_BITS-1:0];
                end
                svgc_pkg::REG_IMAGE_HEIGHT: begin
                    r_img_height <= pwdata[svgc_pkg::REG_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size, out-of-range values clamped
    always_comb begin
        w_eff = DW'(r_img_width);
        if (r_img_width == '0) begin
            w_eff = DW'(1);
        end else if (DW'(r_img_width) > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end
        h_eff = HW'(r_img_height);
        if (r_img_height == '0) begin
            h_eff = HW'(1);
        end else if (HW'(r_img_height) > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end
    end

    // ------------------------------------------------------------------------
    // position decode
    // ------------------------------------------------------------------------
    assign col_ext      = DW'(r_col);
    assign row_ext      = HW'(r_row);
    assign is_last_col  = (col_ext == w_eff - DW'(1));
    assign in_image     = (row_ext < h_eff);
    assign at_drain_row = (row_ext == h_eff);
    assign row_ge1      = (r_row != '0);
    assign row_ge2      = (r_row > RW'(1));

    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (is_last_col) begin
                n_col = '0;
                n_row = at_drain_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // line memory: upper byte two rows up, lower byte one row up
    // ------------------------------------------------------------------------
    svgc_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (wr_pair),
        .i_rd_addr (n_col),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
        end else begin
            r_byp_vld <= accept && (r_col == n_col);
        end
        r_byp_data <= wr_pair;
    end

    assign pair    = r_byp_vld ? r_byp_data : ram_rd_data;
    assign v_pix   = (i_in.kind || !in_image) ? '0 : i_in.pixel;
    assign t_pix   = row_ge2 ? pair[MW-1:PW] : '0;
    assign wr_pair = {pair[PW-1:0], v_pix};

    // ------------------------------------------------------------------------
    // window and gradients
    // ------------------------------------------------------------------------
    assign base_win = (r_col == '0) ? '0 : r_win;
    assign n_win    = svgc_pkg::window_shift(base_win, v_pix, t_pix);

    assign res_a_vld       = row_ge1 && (r_col != '0);
    assign res_b_vld       = row_ge1 && is_last_col;
    assign res_a.gradient  = svgc_pkg::window_grad(n_win);
    assign res_a.frame_end = 1'b0;
    assign res_b.gradient  = svgc_pkg::window_grad(svgc_pkg::window_shift(n_win, '0, '0));
    assign res_b.frame_end = at_drain_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (cfg_wr) begin
                r_win <= '0;
            end else if (accept) begin
                r_win <= n_win;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------------
    assign push0      = accept && (res_a_vld || res_b_vld);
    assign push1      = accept && res_a_vld && res_b_vld;
    assign push_first = res_a_vld ? res_a : res_b;
    assign pop        = o_out.valid && o_out.ready;
    assign wp_next    = r_wp + svgc_pkg::FIFO_PTR_BITS'(1);

    assign i_in.ready = (r_cnt <= svgc_pkg::FIFO_CNT_BITS'(svgc_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_fifo[r_wp] <= push_first;
        end
        if (push1) begin
            r_fifo[wp_next] <= res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + svgc_pkg::FIFO_PTR_BITS'(push0) + svgc_pkg::FIFO_PTR_BITS'(push1);
            r_rp  <= r_rp + svgc_pkg::FIFO_PTR_BITS'(pop);
            r_cnt <= r_cnt + svgc_pkg::FIFO_CNT_BITS'(push0)
                   + svgc_pkg::FIFO_CNT_BITS'(push1) - svgc_pkg::FIFO_CNT_BITS'(pop);
        end
    end

    assign head            = r_fifo[r_rp];
    assign o_out.valid     = (r_cnt != '0);
    assign o_out.gradient  = head.gradient;
    assign o_out.frame_end = head.frame_end;

endmodule

@@ test/sobel_vertical_gradient_clamp_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_vertical_gradient_clamp_unit_tb
// Self-checking testbench for the streaming vertical Sobel gradient unit.
// ----------------------------------------------------------------------------
// A line-buffer model of the filter predicts the gradient items that every
// accepted item causes. A monitor compares each gradient item with the
// oldest prediction. The run checks the reset geometry, clamping at both ends,
// drain and pixel items out of place, mid-frame restarts, out-of-range widths
// and heights, frame wrap, and random frames under three idle patterns.
// ----------------------------------------------------------------------------
module sobel_vertical_gradient_clamp_unit_tb;

    localparam int LINE_DEPTH   = 512;
    localparam int MAX_ROWS     = 512;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [svgc_pkg::ADDR_BITS-1:0]     paddr;
    logic [svgc_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [svgc_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    svgc_in_if  pix_if ();
    svgc_out_if grad_if ();

    sobel_vertical_gradient_clamp_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pix_if),
        .o_out   (grad_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // filter model state
    logic [svgc_pkg::PIX_BITS-1:0] upper_line [LINE_DEPTH];
    logic [svgc_pkg::PIX_BITS-1:0] lower_line [LINE_DEPTH];
    svgc_pkg::t_window             sobel_win;
    logic [8:0]                    col_pos;
    logic [svgc_pkg::REG_BITS-1:0] row_pos;
    logic [svgc_pkg::REG_BITS-1:0] width_reg;
    logic [svgc_pkg::REG_BITS-1:0] height_reg;
    svgc_pkg::t_result             pending_gradients [$];

    int mismatch_count;
    int items_sent;
    int cycle_count;
    int src_idle_pct;
    int snk_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int effective_dim(input logic [svgc_pkg::REG_BITS-1:0] v,
                                         input int max_dim);
        if (v == 0) return 1;
        if (int'(v) > max_dim) return max_dim;
        return int'(v);
    endfunction

    function automatic svgc_pkg::t_window slide_window(
        input svgc_pkg::t_window w,
        input logic [svgc_pkg::PIX_BITS-1:0] bottom_pix,
        input logic [svgc_pkg::PIX_BITS-1:0] top_pix);
        svgc_pkg::t_window s;
        s       = w;
        s.bot_l = w.bot_c;
        s.bot_c = w.bot_r;
        s.bot_r = bottom_pix;
        s.top_l = w.top_c;
        s.top_c = w.top_r;
        s.top_r = top_pix;
        return s;
    endfunction

    function automatic logic [svgc_pkg::PIX_BITS-1:0] clamped_gradient(
        input svgc_pkg::t_window w);
        int lower_sum;
        int upper_sum;
        int diff;
        lower_sum = int'(w.bot_l) + 2 * int'(w.bot_c) + int'(w.bot_r);
        upper_sum = int'(w.top_l) + 2 * int'(w.top_c) + int'(w.top_r);
        diff      = lower_sum - upper_sum;
        if (diff < 0) return '0;
        if (diff > 255) return svgc_pkg::PIX_MAX;
        return diff[svgc_pkg::PIX_BITS-1:0];
    endfunction

    function automatic void restart_frame();
        col_pos   = '0;
        row_pos   = '0;
        sobel_win = '0;
    endfunction

    function automatic void predict_item(input logic kind,
                                         input logic [svgc_pkg::PIX_BITS-1:0] pixel);
        int                            w;
        int                            h;
        int                            c;
        int                            r;
        logic [svgc_pkg::PIX_BITS-1:0] bottom_pix;
        logic [svgc_pkg::PIX_BITS-1:0] top_pix;
        svgc_pkg::t_result             res;
        w = effective_dim(width_reg, LINE_DEPTH);
        h = effective_dim(height_reg, MAX_ROWS);
        c = int'(col_pos);
        r = int'(row_pos);
        if (c >= w) c = w - 1;
        if (r > h) r = h;
        // a drain item, or any item below the image, enters as a zero pixel
        bottom_pix = (kind || r >= h) ? '0 : pixel;
        top_pix    = (r >= 2) ? upper_line[c] : '0;
        if (c == 0) sobel_win = '0;
        sobel_win     = slide_window(sobel_win, bottom_pix, top_pix);
        upper_line[c] = lower_line[c];
        lower_line[c] = bottom_pix;
        if (r >= 1) begin
            if (c >= 1) begin
                res.gradient  = clamped_gradient(sobel_win);
                res.frame_end = 1'b0;
                pending_gradients.push_back(res);
            end
            // last column also closes its own window against a zero column
            if (c == w - 1) begin
                res.gradient  = clamped_gradient(slide_window(sobel_win, '0, '0));
                res.frame_end = (r == h);
                pending_gradients.push_back(res);
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r > h) r = 0;
        end
        col_pos = c[8:0];
        row_pos = r[svgc_pkg::REG_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        svgc_pkg::t_result predicted;
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                predict_item(pix_if.kind, pix_if.pixel);
            end
            if (grad_if.valid && grad_if.ready) begin
                if (pending_gradients.size() == 0) begin
                    $display("%0t: unexpected gradient item %0d frame_end %0b", $time,
                             grad_if.gradient, grad_if.frame_end);
                    mismatch_count++;
                end else begin
                    predicted = pending_gradients.pop_front();
                    if (grad_if.gradient !== predicted.gradient) begin
                        $display("%0t: gradient expected %0d actual %0d", $time,
                                 predicted.gradient, grad_if.gradient);
                        mismatch_count++;
                    end
                    if (grad_if.frame_end !== predicted.frame_end) begin
                        $display("%0t: frame_end expected %0b actual %0b", $time,
                                 predicted.frame_end, grad_if.frame_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        grad_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [svgc_pkg::PIX_BITS-1:0] pixel);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.kind  <= kind;
        pix_if.pixel <= pixel;
        do @(posedge i_clk); while (!pix_if.ready);
        items_sent++;
    endtask

    task automatic wait_for_idle();
        pix_if.valid <= 1'b0;
        do begin
            while (pending_gradients.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end while (pending_gradients.size() != 0);
    endtask

    task automatic apb_transfer(input logic wr, input logic [svgc_pkg::ADDR_BITS-1:0] addr,
                                input logic [svgc_pkg::APB_DATA_BITS-1:0] data,
                                output logic [svgc_pkg::APB_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [svgc_pkg::ADDR_BITS-1:0] reg_addr(
        input svgc_pkg::t_reg_idx idx);
        return svgc_pkg::ADDR_BITS'(idx) << svgc_pkg::REG_SEL_BIT;
    endfunction

    task automatic check_reg(input svgc_pkg::t_reg_idx idx,
                             input logic [svgc_pkg::REG_BITS-1:0] value);
        logic [svgc_pkg::APB_DATA_BITS-1:0] rdata;
        apb_transfer(1'b0, reg_addr(idx), '0, rdata);
        if (rdata[svgc_pkg::REG_BITS-1:0] !== value) begin
            $display("%0t: register %s expected %0d actual %0d", $time, idx.name(),
                     value, rdata[svgc_pkg::REG_BITS-1:0]);
            mismatch_count++;
        end
    endtask

    task automatic write_reg(input svgc_pkg::t_reg_idx idx,
                             input logic [svgc_pkg::REG_BITS-1:0] value);
        logic [svgc_pkg::APB_DATA_BITS-1:0] data;
        logic [svgc_pkg::APB_DATA_BITS-1:0] rdata;
        data                          = $urandom();
        data[svgc_pkg::REG_BITS-1:0]  = value;
        apb_transfer(1'b1, reg_addr(idx), data, rdata);
        if (idx == svgc_pkg::REG_IMAGE_WIDTH) width_reg = value;
        else height_reg = value;
        restart_frame();
        check_reg(idx, value);
    endtask

    task automatic set_geometry(input logic [svgc_pkg::REG_BITS-1:0] w,
                                input logic [svgc_pkg::REG_BITS-1:0] h);
        wait_for_idle();
        write_reg(svgc_pkg::REG_IMAGE_WIDTH, w);
        write_reg(svgc_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [svgc_pkg::PIX_BITS-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return svgc_pkg::PIX_MAX;
            default: return svgc_pkg::PIX_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame from the current position: pixels then the drain row
    task automatic run_frame(input bit scramble, input bit truncate, output bit cut);
        int   w;
        int   h;
        int   total;
        int   n;
        logic kind;
        w     = effective_dim(width_reg, LINE_DEPTH);
        h     = effective_dim(height_reg, MAX_ROWS);
        total = w * (h + 1);
        n     = truncate ? $urandom_range(1, total - 1) : total;
        cut   = truncate;
        for (int i = 0; i < n; i++) begin
            kind = (i >= w * h);
            if (scramble && $urandom_range(0, 99) < 15) kind = ~kind;
            send_item(kind, pick_pixel());
        end
    endtask

    task automatic test_reset_geometry();
        check_reg(svgc_pkg::REG_IMAGE_WIDTH, svgc_pkg::IMAGE_WIDTH_RESET);
        check_reg(svgc_pkg::REG_IMAGE_HEIGHT, svgc_pkg::IMAGE_HEIGHT_RESET);
        // a few items of the first row
        for (int i = 0; i < 4; i++) send_item(1'b0, pick_pixel());
        wait_for_idle();
    endtask

    task automatic test_clamp_and_stray_kinds();
        logic [svgc_pkg::PIX_BITS:0] seq [12];
        bit                          cut;
        // {kind, pixel}: dark row, bright row, row with a drain item inside,
        // drain row with a pixel item inside
        seq = '{9'h000, 9'h000, 9'h000,
                9'h0FF, 9'h0FF, 9'h0FF,
                9'h1FF, 9'h007, 9'h0C8,
                9'h063, 9'h1FF, 9'h100};
        set_geometry(10'd3, 10'd3);
        foreach (seq[i]) send_item(seq[i][svgc_pkg::PIX_BITS], seq[i][svgc_pkg::PIX_BITS-1:0]);
        // restart in the middle of a frame
        for (int i = 0; i < 4; i++) send_item(1'b0, pick_pixel());
        wait_for_idle();
        write_reg(svgc_pkg::REG_IMAGE_HEIGHT, 10'd2);
        run_frame(1'b0, 1'b0, cut);
        wait_for_idle();
    endtask

    task automatic test_dimension_limits();
        bit cut;
        // zero acts as one; two frames back to back wrap
        set_geometry(10'd0, 10'd0);
        run_frame(1'b0, 1'b0, cut);
        run_frame(1'b0, 1'b0, cut);
        // full first row plus a few items of the second
        set_geometry(10'd1023, 10'd1);
        for (int i = 0; i < LINE_DEPTH + 4; i++) send_item(1'b0, pick_pixel());
        set_geometry(10'd1, 10'd1023);
        run_frame(1'b0, 1'b0, cut);
        wait_for_idle();
    endtask

    task automatic run_random_phase(input int src_pct, input int snk_pct, input int item_goal);
        int                            start;
        bit                            cut;
        logic [svgc_pkg::REG_BITS-1:0] w;
        logic [svgc_pkg::REG_BITS-1:0] h;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start        = items_sent;
        cut          = 1'b1;
        while (items_sent - start < item_goal) begin
            if (cut || $urandom_range(0, 99) < 60) begin
                case ($urandom_range(0, 19))
                    0:       w = '0;
                    1:       w = svgc_pkg::REG_BITS'($urandom_range(13, 40));
                    default: w = svgc_pkg::REG_BITS'($urandom_range(1, 12));
                endcase
                case ($urandom_range(0, 19))
                    0:       h = '0;
                    1:       h = svgc_pkg::REG_BITS'($urandom_range(7, 20));
                    default: h = svgc_pkg::REG_BITS'($urandom_range(1, 6));
                endcase
                wait_for_idle();
                case ($urandom_range(0, 3))
                    0:       write_reg(svgc_pkg::REG_IMAGE_WIDTH, w);
                    1:       write_reg(svgc_pkg::REG_IMAGE_HEIGHT, h);
                    default: set_geometry(w, h);
                endcase
            end
            run_frame($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, cut);
        end
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        run_random_phase(33, 57, 160);
        run_random_phase(57, 33, 160);
        run_random_phase(0, 0, 160);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        pix_if.valid   <= 1'b0;
        pix_if.kind    <= 1'b0;
        pix_if.pixel   <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        mismatch_count = 0;
        items_sent     = 0;
        cycle_count    = 0;
        src_idle_pct   = 33;
        snk_idle_pct   = 57;
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        width_reg  = svgc_pkg::IMAGE_WIDTH_RESET;
        height_reg = svgc_pkg::IMAGE_HEIGHT_RESET;
        restart_frame();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_clamp_and_stray_kinds();
        test_dimension_limits();
        test_random_traffic();

        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/svgc_pkg.sv
design/svgc_if.sv
design/svgc_ram.sv
design/sobel_vertical_gradient_clamp_unit.sv
test/sobel_vertical_gradient_clamp_unit_tb.sv
